[rtl/core/history_ring_queue_unit_macros.svh]
// Assertion macros used by the history ring queue sequencer.
`ifndef HISTORY_RING_QUEUE_UNIT_MACROS_SVH
`define HISTORY_RING_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HRQ_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define HRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HRQ_ASSERT(label, ante, cons, msg)
`define HRQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/core/hrq_pkg.sv]
// Types and constants shared by the history ring queue modules.
package hrq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int ITEM_WIDTH_DEFAULT = 32;
   localparam int CSR_DATA_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int QLEN_WIDTH         = 5;
   localparam int MASK_WIDTH         = 32;
   localparam int REQ_TYPE_WIDTH     = 3;
   localparam int POS_WIDTH          = 4;
   localparam int COUNT_WIDTH        = 4;

   localparam logic [QLEN_WIDTH-1:0] QLEN_RESET = QLEN_WIDTH'(16);

   typedef enum logic [REQ_TYPE_WIDTH-1:0] {
      OP_CLEAR       = 3'd0,
      OP_PUSH        = 3'd1,
      OP_POP         = 3'd2,
      OP_PEEK_OLDEST = 3'd3,
      OP_PEEK_OFFSET = 3'd4,
      OP_MOVE_TOP    = 3'd5,
      OP_FIND        = 3'd6
   } hrq_op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_QUEUE_LENGTH = 1'b0,
      CSR_MATCH_MASK   = 1'b1
   } hrq_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_LOAD
   } hrq_state_type;

endpackage

[rtl/core/hrq_if.sv]
// Request and response channel interfaces of the history ring queue.
interface hrq_req_if import hrq_pkg::*; #(
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
) ();
   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_WIDTH-1:0] req_type;
   logic [ITEM_WIDTH-1:0]     item_in;
   logic [POS_WIDTH-1:0]      position;

   modport source (output valid, output req_type, output item_in, output position,
                   input ready);
   modport sink   (input valid, input req_type, input item_in, input position,
                   output ready);
endinterface

interface hrq_rsp_if import hrq_pkg::*; #(
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
) ();
   logic                   valid;
   logic                   ready;
   logic [ITEM_WIDTH-1:0]  item_out;
   logic [POS_WIDTH-1:0]   position_out;
   logic                   hit;
   logic [COUNT_WIDTH-1:0] count;

   modport source (output valid, output item_out, output position_out, output hit,
                   output count, input ready);
   modport sink   (input valid, input item_out, input position_out, input hit,
                   input count, output ready);
endinterface

[rtl/core/hrq_cell.sv]
// One storage cell of the entry chain, loading its neighbour's entry on a shift.
module hrq_cell import hrq_pkg::*; #(
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  shift,
   input  logic [ITEM_WIDTH-1:0] data_in,
   output logic [ITEM_WIDTH-1:0] data_out
);

   logic [ITEM_WIDTH-1:0] entry_ff;
   logic [ITEM_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = shift ? data_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data_out = entry_ff;

endmodule

[rtl/core/hrq_ctrl.sv]
// Sequencer of the history ring queue: request decode, chain passes and response register.
`include "history_ring_queue_unit_macros.svh"
module hrq_ctrl import hrq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   hrq_req_if.sink                    req,
   hrq_rsp_if.source                  rsp,
   input  logic [ITEM_WIDTH-1:0]      head,
   output logic [ITEM_WIDTH-1:0]      tail,
   output logic                       shift
);

   localparam int CW = $clog2(DEPTH);
   localparam logic [CW-1:0] LAST = CW'(DEPTH - 1);

   // Capacity is one less than the clamped ring length.
   function automatic logic [CW-1:0] capacity(input logic [QLEN_WIDTH-1:0] qlen);
      logic [CW-1:0] cap;
      if (qlen < QLEN_WIDTH'(2)) begin
         cap = CW'(1);
      end else if (32'(qlen) > 32'(DEPTH)) begin
         cap = LAST;
      end else begin
         cap = CW'(qlen - QLEN_WIDTH'(1));
      end
      return cap;
   endfunction

   hrq_state_type state_ff, state_in;
   hrq_op_type    op_ff, op_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] target_ff, target_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          hit_ff, hit_in;
   logic [MASK_WIDTH-1:0] mask_ff, mask_in;
   logic [ITEM_WIDTH-1:0] entry_ff, entry_in;
   logic [ITEM_WIDTH-1:0] delay_ff, delay_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ITEM_WIDTH-1:0]  rsp_item_ff, rsp_item_in;
   logic [POS_WIDTH-1:0]   rsp_pos_ff, rsp_pos_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   hrq_op_type            req_op;
   logic                  accept;
   logic                  pos_ok;
   logic                  req_hit;
   logic [CW-1:0]         req_target;
   logic                  last_step;
   logic                  rsp_load;
   logic [ITEM_WIDTH-1:0] mask_ext;
   logic                  key_match;

   assign req_op    = hrq_op_type'(req.req_type);
   assign accept    = req.valid && req.ready;
   assign pos_ok    = 32'(req.position) < 32'(count_ff);
   assign last_step = step_ff == LAST;
   assign mask_ext  = ITEM_WIDTH'(mask_ff);
   assign key_match = ((head ^ entry_ff) & mask_ext) == '0;

   // Decode of the incoming word: whether it addresses a held entry, and which step.
   always_comb begin
      req_hit    = 1'b0;
      req_target = '0;
      case (req_op)
         OP_POP, OP_PEEK_OLDEST: begin
            req_hit    = count_ff != '0;
            req_target = CW'(count_ff - 1'b1);
         end
         OP_PEEK_OFFSET: begin
            req_hit    = pos_ok;
            req_target = CW'(req.position);
         end
         OP_MOVE_TOP: begin
            req_hit    = pos_ok && (req.position != '0);
            req_target = CW'(req.position);
         end
         OP_PUSH: begin
            req_target = LAST;
         end
         default: begin
            req_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_PUSH: begin
                     state_in = ST_SHIFT;
                  end
                  OP_FIND: begin
                     state_in = (count_ff != '0) ? ST_SCAN : ST_LOAD;
                  end
                  default: begin
                     state_in = req_hit ? ST_SCAN : ST_LOAD;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (last_step) begin
               state_in = (op_ff == OP_MOVE_TOP) ? ST_SHIFT : ST_LOAD;
            end
         end
         ST_SHIFT: begin
            if (last_step) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A scan only rotates the chain; a shift pass inserts the held entry at the
   // newest place and moves the entries up to the target step back by one.
   always_comb begin
      req.ready = 1'b0;
      shift     = 1'b0;
      tail      = head;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
         end
         ST_SCAN: begin
            shift = 1'b1;
         end
         ST_SHIFT: begin
            shift = 1'b1;
            if (step_ff == '0) begin
               tail = entry_ff;
            end else if (step_ff <= target_ff) begin
               tail = delay_ff;
            end
         end
         ST_LOAD: begin
            rsp_load = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      step_in      = step_ff;
      target_in    = target_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      mask_in      = mask_ff;
      entry_in     = entry_ff;
      delay_in     = delay_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;

      if (accept) begin
         op_in     = req_op;
         entry_in  = req.item_in;
         hit_in    = req_hit;
         target_in = req_target;
         limit_in  = count_ff;
         pos_in    = '0;
         step_in   = '0;
         case (req_op)
            OP_CLEAR: begin
               count_in = '0;
            end
            OP_PUSH: begin
               if (count_ff < cap_ff) begin
                  count_in = CW'(count_ff + 1'b1);
               end
            end
            OP_POP: begin
               if (count_ff != '0) begin
                  count_in = CW'(count_ff - 1'b1);
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end

      if (state_ff == ST_SCAN) begin
         step_in = last_step ? '0 : CW'(step_ff + 1'b1);
         if (op_ff == OP_FIND) begin
            if (!hit_ff && (step_ff < limit_ff) && key_match) begin
               hit_in = 1'b1;
               pos_in = step_ff;
            end
         end else if (step_ff == target_ff) begin
            entry_in = head;
         end
      end

      if (state_ff == ST_SHIFT) begin
         step_in  = last_step ? '0 : CW'(step_ff + 1'b1);
         delay_in = head;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = (hit_ff && (op_ff != OP_FIND)) ? entry_ff : '0;
         rsp_pos_in   = POS_WIDTH'(pos_ff);
         rsp_hit_in   = hit_ff;
         rsp_count_in = COUNT_WIDTH'(count_ff);
      end else if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Rewriting the length empties the queue; entries stay in the chain.
      if (csr_we) begin
         case (hrq_csr_type'(csr_index))
            CSR_QUEUE_LENGTH: begin
               cap_in   = capacity(csr_wdata[QLEN_WIDTH-1:0]);
               count_in = '0;
            end
            CSR_MATCH_MASK: begin
               mask_in = csr_wdata[MASK_WIDTH-1:0];
            end
            default: begin
               mask_in = mask_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_CLEAR;
         step_ff      <= '0;
         target_ff    <= '0;
         limit_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= capacity(QLEN_RESET);
         pos_ff       <= '0;
         hit_ff       <= 1'b0;
         mask_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         target_ff    <= target_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         pos_ff       <= pos_in;
         hit_ff       <= hit_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      delay_ff     <= delay_in;
      rsp_item_ff  <= rsp_item_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.item_out     = rsp_item_ff;
   assign rsp.position_out = rsp_pos_ff;
   assign rsp.hit          = rsp_hit_ff;
   assign rsp.count        = rsp_count_ff;

   `HRQ_ASSERT(count_within_capacity, 1'b1, count_ff <= cap_ff, "count exceeds capacity")
   `HRQ_ASSERT(idle_step_cleared, state_ff == ST_IDLE, step_ff == '0, "step not cleared in idle")
   `HRQ_ASSERT_NEXT(shift_pass_ends, (state_ff == ST_SHIFT) && last_step,
                    state_ff == ST_LOAD, "shift pass did not end")
   `HRQ_ASSERT(find_within_held, (op_ff == OP_FIND) && hit_ff,
               pos_ff < limit_ff, "find hit beyond held items")

endmodule

[rtl/core/history_ring_queue_unit.sv]
// Top level of the history ring queue: the entry chain and its sequencer.
//
//   channel   direction  handshake       payload
//   req_port  in         valid / ready   req_type, item_in, position
//   rsp_port  out        valid / ready   item_out, position_out, hit, count
//   csr_*     in         csr_we          csr_index, csr_wdata
//
// Entries sit in a chain of DEPTH cells, newest first, and every pass rotates the whole chain
// once, one cell a cycle. A push, pop, peek or find makes one pass, then loads the response;
// a move to the top makes two passes, a scan and a shift, before the load; a clear, an unused
// code or a request that misses the held items goes straight to the load step. A word is
// accepted only when the sequencer is idle. Reset empties the queue, sets the length to 16 and
// the match mask to all ones, and leaves the cell contents as they were. A stalled response
// holds in its register while the next word is processed, which then waits in its load step.
module history_ring_queue_unit import hrq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   hrq_req_if.sink                    req_port,
   hrq_rsp_if.source                  rsp_port,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
   logic [ITEM_WIDTH-1:0] tail;
   logic                  shift;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [ITEM_WIDTH-1:0] cell_in;
      if (k == DEPTH - 1) begin : g_last
         assign cell_in = tail;
      end else begin : g_mid
         assign cell_in = cell_data[k + 1];
      end
      hrq_cell #(
         .ITEM_WIDTH (ITEM_WIDTH)
      ) u_cell (
         .clock    (clock),
         .shift    (shift),
         .data_in  (cell_in),
         .data_out (cell_data[k])
      );
   end

   hrq_ctrl #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_port),
      .rsp       (rsp_port),
      .head      (cell_data[0]),
      .tail      (tail),
      .shift     (shift)
   );

endmodule
